### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define EPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every rising edge, reset included.
`define EPR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/epr_pkg.sv
`timescale 1ns / 1ps

package epr_pkg;

  // Width of the capture timer.
  localparam int unsigned TimerBits = 16;

  localparam logic [16:0] OneQ16   = 17'd65536;
  localparam logic [16:0] MaxQ8    = 17'd115200;
  localparam logic [16:0] CpwReset =
    (TimerBits >= 16) ? 17'd65536 : 17'(64'd1 << TimerBits);
  localparam logic [15:0] TimerMask = 16'((64'd1 << TimerBits) - 64'd1);

  // Reciprocal of 125 for dividends below 2^23: q = (v * DivRecip) >> 30.
  localparam logic [23:0] DivRecip = 24'd8589935;
  localparam logic [6:0]  Divisor  = 7'd125;

  // Half of one Q0.16 unit, for round to nearest in the blend.
  localparam logic [64:0] BlendRound = 65'd32768;

  // Last step indexes of the shared units.
  localparam logic [2:0] DivLast   = 3'd3;
  localparam logic [2:0] BlendLast = 3'd5;

  // Input command codes.
  localparam logic CmdTick    = 1'b0;
  localparam logic CmdCapture = 1'b1;

  // Configuration register indexes.
  localparam logic CfgIdxCpw    = 1'b0;
  localparam logic CfgIdxWeight = 1'b1;

  typedef struct packed {
    logic       tick;
    logic       rise;
    logic       fall;
    logic       dur;
    logic       div_step;
    logic       blend_step;
    logic       commit;
    logic [2:0] step;
  } epr_cmd_t;

  typedef struct packed {
    logic waiting;
  } epr_sts_t;

endpackage

### rtl/epr_if.sv
`timescale 1ns / 1ps

interface epr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] capture_count;

  modport source (output valid, output cmd, output capture_count, input ready);
  modport sink (input valid, input cmd, input capture_count, output ready);
endinterface

interface epr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] distance_q8;
  logic [31:0] pulse_ticks;

  modport source (output valid, output distance_q8, output pulse_ticks, input ready);
  modport sink (input valid, input distance_q8, input pulse_ticks, output ready);
endinterface

### rtl/epr_ctrl.sv
`timescale 1ns / 1ps

module epr_ctrl import epr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_cmd_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  epr_sts_t sts_i,
  output epr_cmd_t cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDur   = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StBlend = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.step = step_q;
    in_ready_o = (state_q == StIdle);
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_cmd_i == CmdTick) begin
            cmd_o.tick = 1'b1;
          end else if (!sts_i.waiting) begin
            cmd_o.rise = 1'b1;
          end else begin
            cmd_o.fall = 1'b1;
            state_d    = StDur;
          end
        end
      end
      StDur: begin
        cmd_o.dur = 1'b1;
        step_d    = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (step_q == DivLast) begin
          step_d  = '0;
          state_d = StBlend;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      StBlend: begin
        cmd_o.blend_step = 1'b1;
        if (step_q == BlendLast) begin
          step_d  = '0;
          state_d = StOut;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.commit;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/epr_dp.sv
`timescale 1ns / 1ps

module epr_dp import epr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  epr_cmd_t    cmd_i,
  output epr_sts_t    sts_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic [15:0] cap_i,
  output logic [16:0] dist_o,
  output logic [31:0] ticks_o
);

  // Configuration and persistent state.
  logic [16:0] cpw_q;
  logic [16:0] wgt_q;
  logic        wait_q;
  logic [15:0] start_q;
  logic [31:0] ovf_q;
  logic [47:0] filt_q;

  // Working registers of one falling edge.
  logic [15:0] cap_q;
  logic [48:0] prod_q;
  logic [31:0] dur_q;
  logic [6:0]  rem_q;
  logic [47:0] quo_q;
  logic [64:0] acc_q;
  logic [16:0] dist_q;
  logic [31:0] ticks_q;

  logic [48:0] prod_d;
  logic [50:0] diff;
  logic [31:0] dur_d;
  logic [36:0] dur17;
  logic [63:0] zpad;
  logic [15:0] digit;
  logic [22:0] dv;
  logic [46:0] qm;
  logic [15:0] qd;
  logic [22:0] qx125;
  logic [22:0] rem_full;
  logic [16:0] wc;
  logic [16:0] wi;
  logic [15:0] opa;
  logic [16:0] opb;
  logic [32:0] pp;
  logic [64:0] addend;
  logic [47:0] fnew;
  logic [39:0] q8w;
  logic [16:0] dist_d;

  assign prod_d = {17'b0, ovf_q} * {32'b0, cpw_q};

  // End minus start; a negative result clamps to zero, a long one saturates.
  assign diff  = {2'b0, prod_q} + {35'b0, cap_q} - {35'b0, start_q};
  assign dur_d = diff[50] ? '0 : ((|diff[49:32]) ? '1 : diff[31:0]);

  // The sample is dur * 17 * 8192 / 125, long-divided in 16-bit digits.
  assign dur17 = {1'b0, dur_q, 4'b0} + {5'b0, dur_q};
  assign zpad  = {14'b0, dur17, 13'b0};

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    digit = zpad[63:48];
      2'd1:    digit = zpad[47:32];
      2'd2:    digit = zpad[31:16];
      default: digit = zpad[15:0];
    endcase
  end

  assign dv       = {rem_q, digit};
  assign qm       = {24'b0, dv} * {23'b0, DivRecip};
  assign qd       = qm[45:30];
  assign qx125    = ({7'b0, qd} << 7) - ({7'b0, qd} << 1) - {7'b0, qd};
  assign rem_full = dv - qx125;

  // Blend: three partial products of the sample, then three of the old value.
  assign wc = (wgt_q > OneQ16) ? OneQ16 : wgt_q;
  assign wi = OneQ16 - wc;

  always_comb begin
    case (cmd_i.step)
      3'd0:    begin opa = quo_q[15:0];   opb = wc; end
      3'd1:    begin opa = quo_q[31:16];  opb = wc; end
      3'd2:    begin opa = quo_q[47:32];  opb = wc; end
      3'd3:    begin opa = filt_q[15:0];  opb = wi; end
      3'd4:    begin opa = filt_q[31:16]; opb = wi; end
      default: begin opa = filt_q[47:32]; opb = wi; end
    endcase
  end

  assign pp = {17'b0, opa} * {16'b0, opb};

  always_comb begin
    case (cmd_i.step)
      3'd0, 3'd3: addend = {32'b0, pp};
      3'd1, 3'd4: addend = {16'b0, pp, 16'b0};
      default:    addend = {pp, 32'b0};
    endcase
  end

  assign fnew   = acc_q[63:16];
  assign q8w    = fnew[47:8];
  assign dist_d = (q8w > {23'b0, MaxQ8}) ? MaxQ8 : q8w[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpw_q   <= CpwReset;
      wgt_q   <= OneQ16;
      wait_q  <= 1'b0;
      start_q <= '0;
      ovf_q   <= '0;
      filt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgIdxCpw:    cpw_q <= cfg_wdata_i;
          CfgIdxWeight: wgt_q <= cfg_wdata_i;
          default:      ;
        endcase
      end
      if (cmd_i.tick && (ovf_q != '1)) begin
        ovf_q <= ovf_q + 32'd1;
      end
      if (cmd_i.rise) begin
        start_q <= cap_i & TimerMask;
        ovf_q   <= '0;
        wait_q  <= 1'b1;
      end
      if (cmd_i.fall) begin
        wait_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        filt_q <= fnew;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fall) begin
      cap_q  <= cap_i & TimerMask;
      prod_q <= prod_d;
    end
    if (cmd_i.dur) begin
      dur_q <= dur_d;
      rem_q <= '0;
      quo_q <= '0;
      acc_q <= BlendRound;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_full[6:0];
      quo_q <= {quo_q[31:0], qd};
    end
    if (cmd_i.blend_step) begin
      acc_q <= acc_q + addend;
    end
    if (cmd_i.commit) begin
      dist_q  <= dist_d;
      ticks_q <= dur_q;
    end
  end

  assign sts_o.waiting = wait_q;
  assign dist_o        = dist_q;
  assign ticks_o       = ticks_q;

endmodule

### rtl/echo_pulse_range_filter_unit.sv
`timescale 1ns / 1ps

// Channel   Role    Payload                        Transfer when
// in_ch     sink    cmd, capture_count             in_ch.valid && in_ch.ready
// out_ch    source  distance_q8, pulse_ticks       out_ch.valid && out_ch.ready
// cfg       write   cfg_idx_i, cfg_wdata_i         cfg_we_i
//
// A tick or a rising edge leaves the unit idle. A falling edge runs the wrap
// multiply, registered with its transfer, then the duration, the divide by 125,
// the blend and the commit; the next item is taken in the cycle after the commit.
// The asynchronous reset clears all but the working and payload registers. A
// result waits in the output register while the next item is taken; a falling
// edge that finishes while that register is still full holds there.

module echo_pulse_range_filter_unit import epr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  epr_in_if.sink      in_ch,
  epr_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  epr_cmd_t cmd;
  epr_sts_t sts;

  // The controller sequences each falling edge through the shared units and
  // owns both handshakes; ticks and rising edges are handled without leaving idle.
  epr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_cmd_i    (in_ch.cmd),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the wrap state, the filter state and
  // the output payload register.
  epr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cap_i       (in_ch.capture_count),
    .dist_o      (out_ch.distance_q8),
    .ticks_o     (out_ch.pulse_ticks)
  );

endmodule

### rtl/epr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module epr_checker import epr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_dist,
  input logic [31:0] out_ticks
);

  `EPR_ASSERT(a_dist_range, clk_i, rst_ni, out_valid |-> (out_dist <= MaxQ8), "distance out of range")
  `EPR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(out_dist) && $stable(out_ticks)), "stalled result changed")
  `EPR_ASSERT(a_tick_fast, clk_i, rst_ni, (in_valid && in_ready && (in_cmd == CmdTick)) |=> in_ready, "tick held the input")
  `EPR_ASSERT(a_result_after_work, clk_i, rst_ni, $rose(out_valid) |-> $past(!in_ready), "result without processing")
  `EPR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid, "result during reset")

endmodule

bind echo_pulse_range_filter_unit epr_checker u_epr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_dist  (out_ch.distance_q8),
  .out_ticks (out_ch.pulse_ticks)
);

### bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the echo ranging unit. A directed table is walked
// first, then a long run of random echo pulses under several register
// settings. Every transfer on the input channel is fed to a predictor kept
// here, and every transfer on the output channel is checked against the
// oldest prediction still waiting.

module testbench;
  import epr_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  // Chosen to cover a falling edge still in the arithmetic.
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 110;

  typedef struct packed {
    logic [16:0] distance_q8;
    logic [31:0] pulse_ticks;
  } range_result_t;

  typedef enum logic {
    RowItem,
    RowConfig
  } row_kind_e;

  // One line of the directed table. A row with known_result set carries the
  // result that is plain from the arithmetic; all other rows lean on the
  // predictor.
  typedef struct packed {
    row_kind_e     kind;
    logic          cmd;
    logic [15:0]   capture;
    int unsigned   reps;
    logic          reg_idx;
    logic [16:0]   reg_value;
    logic          known_result;
    range_result_t result;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [16:0] cfg_wdata_i;

  epr_in_if  in_ch ();
  epr_out_if out_ch ();

  echo_pulse_range_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Register copies and pulse state of the predictor.
  logic [16:0]   cpw_reg;
  logic [16:0]   weight_reg;
  logic          echo_armed;
  logic [15:0]   echo_start;
  logic [31:0]   wrap_count;
  logic [63:0]   filt_q16;

  range_result_t expected_ranges[$];
  stim_row_t     directed_rows[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  // When clear, neither side of the unit idles.
  bit            idle_enable;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Follows one input item through the unit's arithmetic. A result is only
  // formed on the falling edge, i.e. the second capture of a pair.
  function automatic void range_predict(input logic cmd, input logic [15:0] capture,
                                        output bit produced, output range_result_t res);
    logic [63:0] cap_m;
    logic [63:0] end_ticks;
    logic [63:0] dur;
    logic [63:0] sample;
    logic [63:0] w;
    logic [63:0] q8;
    produced = 1'b0;
    res      = '0;
    cap_m    = 64'(capture & TimerMask);
    if (cmd == CmdTick) begin
      if (wrap_count != 32'hFFFF_FFFF) begin
        wrap_count = wrap_count + 32'd1;
      end
    end else if (!echo_armed) begin
      echo_start = cap_m[15:0];
      wrap_count = '0;
      echo_armed = 1'b1;
    end else begin
      echo_armed = 1'b0;
      end_ticks  = cap_m + 64'(wrap_count) * 64'(cpw_reg);
      // A pulse that seems to end before it began counts as zero length.
      dur = (end_ticks >= 64'(echo_start)) ? end_ticks - 64'(echo_start) : 64'd0;
      if (dur > 64'hFFFF_FFFF) begin
        dur = 64'hFFFF_FFFF;
      end
      sample = dur * 64'd17 * 64'd65536 / 64'd1000;
      // A weight above one behaves as exactly one.
      w = (weight_reg > OneQ16) ? 64'(OneQ16) : 64'(weight_reg);
      filt_q16 = (sample * w + filt_q16 * (64'(OneQ16) - w) + 64'd32768) >> 16;
      q8 = filt_q16 >> 8;
      if (q8 > 64'(MaxQ8)) begin
        q8 = 64'(MaxQ8);
      end
      res.distance_q8 = q8[16:0];
      res.pulse_ticks = dur[31:0];
      produced = 1'b1;
    end
  endfunction

  function automatic stim_row_t item_row(input logic cmd, input logic [15:0] capture,
                                         input int unsigned reps);
    stim_row_t r;
    r         = '0;
    r.kind    = RowItem;
    r.cmd     = cmd;
    r.capture = capture;
    r.reps    = reps;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [15:0] capture,
                                          input logic [16:0] distance,
                                          input logic [31:0] ticks);
    stim_row_t r;
    r                    = item_row(CmdCapture, capture, 1);
    r.known_result       = 1'b1;
    r.result.distance_q8 = distance;
    r.result.pulse_ticks = ticks;
    return r;
  endfunction

  function automatic stim_row_t config_row(input logic idx, input logic [16:0] value);
    stim_row_t r;
    r           = '0;
    r.kind      = RowConfig;
    r.reg_idx   = idx;
    r.reg_value = value;
    return r;
  endfunction

  // Offers one item, with a random gap before it while idling is on, and
  // waits for its transfer. The predictor runs at the edge of the transfer.
  task automatic send_range_item(input logic cmd, input logic [15:0] capture,
                                 input logic known, input range_result_t known_res);
    int unsigned   gap;
    bit            produced;
    range_result_t res;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.capture_count <= capture;
    do @(posedge clk_i); while (!in_ch.ready);
    range_predict(cmd, capture, produced, res);
    if (produced) begin
      expected_ranges.push_back(known ? known_res : res);
    end
  endtask

  // Registers only change while the unit is quiet: the input is withdrawn,
  // every predicted result must have come out, and a falling edge still in
  // the arithmetic is given time to finish.
  task automatic write_register(input logic idx, input logic [16:0] value);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxCpw) begin
      cpw_reg = value;
    end else begin
      weight_reg = value;
    end
  endtask

  // Receiver side: ready drops in short random bursts while idling is on.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        stall_left   = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every output transfer is held against the oldest prediction.
  always @(posedge clk_i) begin
    range_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_ranges.size() == 0) begin
        $error("unexpected result: distance_q8 %0d, pulse_ticks %0d",
               out_ch.distance_q8, out_ch.pulse_ticks);
        error_count++;
      end else begin
        want = expected_ranges.pop_front();
        if (out_ch.distance_q8 !== want.distance_q8) begin
          $error("distance_q8 mismatch: expected %0d, actual %0d",
                 want.distance_q8, out_ch.distance_q8);
          error_count++;
        end
        if (out_ch.pulse_ticks !== want.pulse_ticks) begin
          $error("pulse_ticks mismatch: expected %0d, actual %0d",
                 want.pulse_ticks, out_ch.pulse_ticks);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned   phase;
    int unsigned   phase_count;
    int unsigned   n_ticks;
    int unsigned   noise_len;
    int unsigned   row_ix;
    logic [16:0]   cpw_val;
    logic [16:0]   weight_val;
    logic [15:0]   start_cap;
    logic [15:0]   fall_cap;
    range_result_t no_res;

    no_res              = '0;
    error_count         = 0;
    idle_enable         = 1'b1;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CmdTick;
    in_ch.capture_count = '0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CfgIdxCpw;
    cfg_wdata_i         = '0;

    cpw_reg    = CpwReset;
    weight_reg = OneQ16;
    echo_armed = 1'b0;
    echo_start = '0;
    wrap_count = '0;
    filt_q16   = '0;

    // Straight after reset the weight is one, so the filter simply follows
    // the new sample; that makes the first few results plain to see.
    // Zero-length pulse.
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    directed_rows.push_back(known_row(16'h0000, 17'd0, 32'd0));
    // Widest pulse within one wrap, far beyond the range clamp.
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    directed_rows.push_back(known_row(16'hFFFF, MaxQ8, 32'd65535));
    // Falling edge earlier than the rising one: the length is taken as zero.
    directed_rows.push_back(item_row(CmdCapture, 16'd1000, 1));
    directed_rows.push_back(known_row(16'd10, 17'd0, 32'd0));
    // A tick between pulses still counts, and is then cleared by the rise.
    directed_rows.push_back(item_row(CmdTick, 16'hFFFF, 1));
    directed_rows.push_back(item_row(CmdCapture, 16'd500, 1));
    directed_rows.push_back(item_row(CmdTick, 16'h0000, 1));
    directed_rows.push_back(item_row(CmdCapture, 16'd500, 1));
    // Weight above one.
    directed_rows.push_back(config_row(CfgIdxWeight, 17'h1FFFF));
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    directed_rows.push_back(item_row(CmdCapture, 16'd1000, 1));
    // Zero weight: the filter must hold its value.
    directed_rows.push_back(config_row(CfgIdxWeight, 17'd0));
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    directed_rows.push_back(item_row(CmdCapture, 16'd2000, 1));
    // Zero counts per wrap: ticks add nothing to the length.
    directed_rows.push_back(config_row(CfgIdxCpw, 17'd0));
    directed_rows.push_back(config_row(CfgIdxWeight, 17'd32768));
    directed_rows.push_back(item_row(CmdCapture, 16'd100, 1));
    directed_rows.push_back(item_row(CmdTick, 16'h1234, 3));
    directed_rows.push_back(item_row(CmdCapture, 16'd200, 1));
    // One count per wrap with the end still short of the start.
    directed_rows.push_back(config_row(CfgIdxCpw, 17'd1));
    directed_rows.push_back(item_row(CmdCapture, 16'hFFFF, 1));
    directed_rows.push_back(item_row(CmdTick, 16'h0000, 5));
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    // Widest wrap length with two wraps: 65535 + 2 * 131071 ticks, and a
    // distance well beyond the clamp.
    directed_rows.push_back(config_row(CfgIdxCpw, 17'h1FFFF));
    directed_rows.push_back(config_row(CfgIdxWeight, OneQ16));
    directed_rows.push_back(item_row(CmdCapture, 16'h0000, 1));
    directed_rows.push_back(item_row(CmdTick, 16'h0000, 2));
    directed_rows.push_back(known_row(16'hFFFF, MaxQ8, 32'd327677));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (row_ix = 0; row_ix < directed_rows.size(); row_ix++) begin
      if (directed_rows[row_ix].kind == RowConfig) begin
        write_register(directed_rows[row_ix].reg_idx, directed_rows[row_ix].reg_value);
      end else begin
        repeat (directed_rows[row_ix].reps) begin
          send_range_item(directed_rows[row_ix].cmd, directed_rows[row_ix].capture,
                          directed_rows[row_ix].known_result,
                          directed_rows[row_ix].result);
        end
      end
    end

    // Random part: one register setting per phase, extremes first. Phases four
    // and seven run with no idling at all, the last one closing the run.
    for (phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin
          cpw_val    = CpwReset;
          weight_val = OneQ16;
        end
        1: begin
          cpw_val    = 17'd1;
          weight_val = 17'd0;
        end
        2: begin
          cpw_val    = 17'h1FFFF;
          weight_val = 17'h1FFFF;
        end
        3: begin
          cpw_val    = 17'd0;
          weight_val = 17'd1;
        end
        default: begin
          cpw_val    = 17'($urandom_range(0, 17'h1FFFF));
          weight_val = 17'($urandom_range(0, 17'h1FFFF));
        end
      endcase
      write_register(CfgIdxCpw, cpw_val);
      write_register(CfgIdxWeight, weight_val);
      idle_enable = (phase != 4) && (phase != PhaseCount - 1);

      phase_count = 0;
      while (phase_count < PhaseItems) begin
        if ($urandom_range(0, 99) < 85) begin
          // A proper pulse: rise, a few wraps, fall. Short pulses are
          // favoured so that most distances stay inside the clamp.
          if (echo_armed) begin
            send_range_item(CmdCapture, 16'($urandom), 1'b0, no_res);
            phase_count++;
          end
          start_cap = 16'($urandom);
          send_range_item(CmdCapture, start_cap, 1'b0, no_res);
          case ($urandom_range(0, 9))
            0:       n_ticks = $urandom_range(3, 8);
            1, 2, 3: n_ticks = $urandom_range(1, 2);
            default: n_ticks = 0;
          endcase
          repeat (n_ticks) send_range_item(CmdTick, 16'($urandom), 1'b0, no_res);
          if ($urandom_range(0, 1) == 0) begin
            fall_cap = start_cap + 16'($urandom_range(0, 30000));
          end else begin
            fall_cap = 16'($urandom);
          end
          send_range_item(CmdCapture, fall_cap, 1'b0, no_res);
          phase_count += 2 + n_ticks;
        end else begin
          // Noise: any mix of ticks and captures, which also leaves pulses
          // half open or out of step.
          noise_len = $urandom_range(1, 3);
          repeat (noise_len) begin
            send_range_item(1'($urandom_range(0, 1)), 16'($urandom), 1'b0, no_res);
          end
          phase_count += noise_len;
        end
      end
    end

    // Drain: withdraw the input, let every predicted result arrive, then give
    // the unit time to show anything that should not be there.
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (expected_ranges.size() != 0) @(posedge clk_i);
    repeat (SettleCycles * 2) @(posedge clk_i);
    if (expected_ranges.size() != 0) begin
      $error("results never delivered: %0d", expected_ranges.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/epr_pkg.sv
rtl/epr_if.sv
rtl/epr_ctrl.sv
rtl/epr_dp.sv
rtl/echo_pulse_range_filter_unit.sv
rtl/epr_checker.sv
bench/testbench.sv
